// ===== sv/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// Holds the configuration record, the result record and the phase codes.
// No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

  localparam int unsigned TICK_COUNT_BITS = 20;
  localparam int unsigned DISTANCE_BITS   = 16;

  localparam int unsigned TRIG_W  = 10;
  localparam int unsigned TOUT_W  = 20;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned ROUND_W = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned TC_W    = TICK_COUNT_BITS;
  localparam int unsigned PROD_W  = TC_W + SCALE_W;
  localparam int unsigned MM_W    = PROD_W + 1 - SCALE_W;
  localparam int unsigned WIDE_W  = 34;
  localparam longint unsigned DIST_LIM =
      (DISTANCE_BITS < DIST_W) ? ((64'd1 << DISTANCE_BITS) - 64'd1) : 64'hFFFF;
  localparam longint unsigned ROUND_HALF = 64'h8000;

  localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 10'd10;
  localparam logic [TOUT_W-1:0]  TIMEOUT_TICKS_RST = 20'd100000;
  localparam logic [SCALE_W-1:0] SCALE_Q16_RST     = 16'd11239;
  localparam logic [DIST_W-1:0]  NEAR_MM_RST       = 16'd200;
  localparam logic [DIST_W-1:0]  CLEAR_MM_RST      = 16'd250;
  localparam logic [ROUND_W-1:0] MEASURES_RST      = 4'd3;
  localparam logic               COUNT_TIMEOUTS_RST = 1'b1;
  localparam logic [DIST_W-1:0]  DISTANCE_RST      = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_TICKS  = 3'd0,
    CFG_TIMEOUT_TICKS  = 3'd1,
    CFG_SCALE_Q16      = 3'd2,
    CFG_NEAR_MM        = 3'd3,
    CFG_CLEAR_MM       = 3'd4,
    CFG_MEASURES       = 3'd5,
    CFG_COUNT_TIMEOUTS = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_TRIGGER = 3'b001,
    PH_WAIT    = 3'b010,
    PH_MEASURE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [TOUT_W-1:0]  timeout_ticks;
    logic [SCALE_W-1:0] scale_q16;
    logic [DIST_W-1:0]  near_mm;
    logic [DIST_W-1:0]  clear_mm;
    logic [ROUND_W-1:0] measures_per_round;
    logic               count_timeouts;
  } cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic [DIST_W-1:0] distance_mm;
    logic              obstacle;
    logic              sample_done;
    logic              echo_timed_out;
    logic              round_done;
  } res_t;

endpackage

// ===== sv/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: input beat register, tick core,
// product register, configuration registers and result register.
// Depends on uer_pkg, uer_cfg, uer_mul and uer_core.
//
//   Channel | Direction | Handshake          | Beat contents
//   in_     | in        | in_valid/in_stall   | echo_level
//   out_    | out       | out_valid/out_stall | trigger, distance, flags
//   cfg_    | in        | cfg_valid/cfg_ready | register index, write data
//
// One beat per cycle is taken while in_stall is low; one result beat is given
// per input beat. A beat passes from the input register into the result register,
// where its result is offered on out_valid until it is taken.
// The width-times-scale product is registered in its own register from next values.
// Reset is synchronous; the core returns to the trigger phase with 1000 mm.
// A stall on a full result register holds it; the input register takes one more
// beat and then raises in_stall. cfg_ready is always high.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_echo_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_trigger_level,
  output logic [uer_pkg::DIST_W-1:0]     out_distance_mm,
  output logic                           out_obstacle,
  output logic                           out_sample_done,
  output logic                           out_echo_timed_out,
  output logic                           out_round_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uer_pkg::*;

  logic  in_vld_r, in_vld_nxt;
  logic  in_echo_r;
  logic  out_vld_r, out_vld_nxt;
  res_t  res_r;
  res_t  res_c;
  cfg_t  cfg_q;
  cfg_t  cfg_d;
  logic  out_free;
  logic  step;
  logic  in_take;
  logic [TC_W-1:0]   width_nxt;
  logic [PROD_W-1:0] prod;

  assign out_free = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  uer_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_q    (cfg_q),
    .cfg_d    (cfg_d)
  );

  uer_mul u_mul (
    .clk       (clk),
    .width_nxt (width_nxt),
    .scale_nxt (cfg_d.scale_q16),
    .prod      (prod)
  );

  uer_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .echo      (in_echo_r),
    .cfg       (cfg_q),
    .prod      (prod),
    .width_nxt (width_nxt),
    .res       (res_c)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (step) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_echo_r <= in_echo_level;
    end
    if (step) begin
      res_r <= res_c;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_trigger_level  = res_r.trigger_level;
  assign out_distance_mm    = res_r.distance_mm;
  assign out_obstacle       = res_r.obstacle;
  assign out_sample_done    = res_r.sample_done;
  assign out_echo_timed_out = res_r.echo_timed_out;
  assign out_round_done     = res_r.round_done;

endmodule

// ===== sv/uer_cfg.sv =====
// Configuration register file of the ultrasonic echo ranger.
// Presents both the current register values and their next values.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] wr_data,
  output uer_pkg::cfg_t                  cfg_q,
  output uer_pkg::cfg_t                  cfg_d
);
  import uer_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_TRIGGER_TICKS:  cfg_nxt.trigger_ticks = wr_data[TRIG_W-1:0];
        CFG_TIMEOUT_TICKS:  cfg_nxt.timeout_ticks = wr_data[TOUT_W-1:0];
        CFG_SCALE_Q16:      cfg_nxt.scale_q16 = wr_data[SCALE_W-1:0];
        CFG_NEAR_MM:        cfg_nxt.near_mm = wr_data[DIST_W-1:0];
        CFG_CLEAR_MM:       cfg_nxt.clear_mm = wr_data[DIST_W-1:0];
        CFG_MEASURES:       cfg_nxt.measures_per_round = wr_data[ROUND_W-1:0];
        CFG_COUNT_TIMEOUTS: cfg_nxt.count_timeouts = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks      <= TRIGGER_TICKS_RST;
      cfg_r.timeout_ticks      <= TIMEOUT_TICKS_RST;
      cfg_r.scale_q16          <= SCALE_Q16_RST;
      cfg_r.near_mm            <= NEAR_MM_RST;
      cfg_r.clear_mm           <= CLEAR_MM_RST;
      cfg_r.measures_per_round <= MEASURES_RST;
      cfg_r.count_timeouts     <= COUNT_TIMEOUTS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_q = cfg_r;
  assign cfg_d = (!rst_n) ? cfg_t'({TRIGGER_TICKS_RST, TIMEOUT_TICKS_RST, SCALE_Q16_RST,
                                    NEAR_MM_RST, CLEAR_MM_RST, MEASURES_RST,
                                    COUNT_TIMEOUTS_RST})
                          : cfg_nxt;

endmodule

// ===== sv/uer_mul.sv =====
// Width-times-scale product register of the ultrasonic echo ranger.
// Tracks the echo width and scale registers so the product is ready on every tick.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_mul (
  input  logic                         clk,
  input  logic [uer_pkg::TC_W-1:0]    width_nxt,
  input  logic [uer_pkg::SCALE_W-1:0] scale_nxt,
  output logic [uer_pkg::PROD_W-1:0]  prod
);
  import uer_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(width_nxt) * PROD_W'(scale_nxt);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== sv/uer_core.sv =====
// Tick state machine of the ultrasonic echo ranger: trigger, wait, measure,
// timeout and round logic with the hysteresis obstacle flag.
// Depends on uer_pkg; takes the width-times-scale product from uer_mul.
`timescale 1ns / 1ps

module uer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        echo,
  input  uer_pkg::cfg_t               cfg,
  input  logic [uer_pkg::PROD_W-1:0]  prod,
  output logic [uer_pkg::TC_W-1:0]    width_nxt,
  output uer_pkg::res_t               res
);
  import uer_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [TRIG_W-1:0]  trig_cnt_r, trig_cnt_nxt;
  logic [TC_W-1:0]    tout_cnt_r, tout_cnt_nxt;
  logic [TC_W-1:0]    width_r, width_calc;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic               obst_r, obst_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;

  logic [PROD_W:0]    prod_rnd;
  logic [MM_W-1:0]    mm_full;
  logic [DIST_W-1:0]  mm_sat;
  logic [TC_W-1:0]    tout_inc;
  logic [TRIG_W-1:0]  trig_inc;
  logic [ROUND_W-1:0] round_inc;
  logic               counted;

  assign prod_rnd = {1'b0, prod} + (PROD_W + 1)'(ROUND_HALF);
  assign mm_full  = prod_rnd[PROD_W:SCALE_W];
  assign mm_sat   = (WIDE_W'(mm_full) > WIDE_W'(DIST_LIM)) ? DIST_W'(DIST_LIM)
                                                          : DIST_W'(mm_full);
  assign tout_inc = (tout_cnt_r == '1) ? tout_cnt_r : tout_cnt_r + 1'b1;
  assign trig_inc = trig_cnt_r + 1'b1;
  assign round_inc = round_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    trig_cnt_nxt = trig_cnt_r;
    tout_cnt_nxt = tout_cnt_r;
    width_calc   = width_r;
    dist_nxt     = dist_r;
    obst_nxt     = obst_r;
    round_nxt    = round_r;
    counted      = 1'b0;
    res          = '0;

    unique case (phase_r)
      PH_WAIT, PH_MEASURE: begin
        tout_cnt_nxt = tout_inc;
        if (phase_r == PH_WAIT) begin
          if (echo) begin
            phase_nxt  = PH_MEASURE;
            width_calc = TC_W'(1);
          end
        end else if (echo) begin
          width_calc = (width_r == '1) ? width_r : width_r + 1'b1;
        end else begin
          dist_nxt         = mm_sat;
          res.sample_done  = 1'b1;
          counted          = 1'b1;
          phase_nxt        = PH_TRIGGER;
          trig_cnt_nxt     = '0;
        end
        if (!res.sample_done && (WIDE_W'(tout_inc) >= WIDE_W'(cfg.timeout_ticks))) begin
          res.echo_timed_out = 1'b1;
          if (cfg.count_timeouts) begin
            counted = 1'b1;
          end
          phase_nxt    = PH_TRIGGER;
          trig_cnt_nxt = '0;
        end
      end
      default: begin
        res.trigger_level = 1'b1;
        trig_cnt_nxt      = trig_inc;
        if (trig_inc >= cfg.trigger_ticks || trig_inc == '0) begin
          phase_nxt    = PH_WAIT;
          trig_cnt_nxt = '0;
          tout_cnt_nxt = '0;
          width_calc   = '0;
        end
      end
    endcase

    if (counted) begin
      round_nxt = round_inc;
      if (round_inc >= cfg.measures_per_round || round_inc == '0) begin
        if (dist_nxt < cfg.near_mm) begin
          obst_nxt = 1'b1;
        end else if (dist_nxt >= cfg.clear_mm) begin
          obst_nxt = 1'b0;
        end
        round_nxt      = '0;
        res.round_done = 1'b1;
      end
    end

    res.distance_mm = dist_nxt;
    res.obstacle    = obst_nxt;
  end

  assign width_nxt = (!rst_n) ? '0 : (step ? width_calc : width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TRIGGER;
      trig_cnt_r <= '0;
      tout_cnt_r <= '0;
      width_r    <= '0;
      dist_r     <= DISTANCE_RST;
      obst_r     <= 1'b0;
      round_r    <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      trig_cnt_r <= trig_cnt_nxt;
      tout_cnt_r <= tout_cnt_nxt;
      width_r    <= width_calc;
      dist_r     <= dist_nxt;
      obst_r     <= obst_nxt;
      round_r    <= round_nxt;
    end
  end

endmodule
